/* rtl/core/ufcd_pkg.sv */
package ufcd_pkg;

	localparam int PAYLOAD_BYTES_DEF = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED     = 2'd2;

	localparam logic [7:0]  START_FIRST_RST  = 8'hAA;
	localparam logic [7:0]  START_SECOND_RST = 8'h55;
	localparam logic [15:0] CRC_SEED_RST     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY         = 16'h1021;

	localparam logic [1:0] STATUS_PAYLOAD = 2'd0;
	localparam logic [1:0] STATUS_BAD_LEN = 2'd1;
	localparam logic [1:0] STATUS_BAD_CRC = 2'd2;

	typedef enum logic [2:0] {
		ST_SOF1,
		ST_SOF2,
		ST_LEN,
		ST_DATA,
		ST_CRC_HI,
		ST_CRC_LO,
		ST_BURST
	} ufcd_state_t;

	typedef struct packed {
		logic in_ready;
		logic crc_seed_load;
		logic crc_update;
		logic cnt_clear;
		logic cnt_inc;
		logic ram_we;
		logic hi_load;
		logic drop_len;
		logic drop_crc;
		logic rd_start;
		logic burst_load;
		logic burst_next;
	} ufcd_cmd_t;

	typedef struct packed {
		logic is_first;
		logic is_second;
		logic len_ok;
		logic crc_ok;
		logic cnt_last;
		logic out_free;
	} ufcd_stat_t;

endpackage

/* rtl/core/ufcd_ram.sv */
module ufcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/ufcd_ctrl.sv */
module ufcd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  ufcd_pkg::ufcd_stat_t stat,
	output ufcd_pkg::ufcd_cmd_t  cmd
);

	import ufcd_pkg::*;

	ufcd_state_t state_q, state_d;
	logic        rx_state;
	logic        acc;

	assign rx_state = (state_q != ST_BURST);
	assign acc      = in_valid && rx_state && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SOF1;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_SOF1: begin
				if (acc && stat.is_first) state_d = ST_SOF2;
			end
			ST_SOF2: begin
				if (acc) begin
					if (stat.is_second)     state_d = ST_LEN;
					else if (stat.is_first) state_d = ST_SOF2;
					else                    state_d = ST_SOF1;
				end
			end
			ST_LEN: begin
				if (acc) begin
					if (stat.len_ok)        state_d = ST_DATA;
					else if (stat.is_first) state_d = ST_SOF2;
					else                    state_d = ST_SOF1;
				end
			end
			ST_DATA: begin
				if (acc && stat.cnt_last) state_d = ST_CRC_HI;
			end
			ST_CRC_HI: begin
				if (acc) state_d = ST_CRC_LO;
			end
			ST_CRC_LO: begin
				if (acc) state_d = stat.crc_ok ? ST_BURST : ST_SOF1;
			end
			ST_BURST: begin
				if (stat.out_free && stat.cnt_last) state_d = ST_SOF1;
			end
			default: begin
				state_d = ST_SOF1;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.in_ready = rx_state && stat.out_free;
		case (state_q)
			ST_LEN: begin
				cmd.crc_seed_load = acc && stat.len_ok;
				cmd.cnt_clear     = acc && stat.len_ok;
				cmd.drop_len      = acc && !stat.len_ok;
			end
			ST_DATA: begin
				cmd.ram_we     = acc;
				cmd.crc_update = acc;
				cmd.cnt_inc    = acc;
			end
			ST_CRC_HI: begin
				cmd.hi_load = acc;
			end
			ST_CRC_LO: begin
				cmd.rd_start = acc && stat.crc_ok;
				cmd.drop_crc = acc && !stat.crc_ok;
			end
			ST_BURST: begin
				cmd.burst_load = stat.out_free;
				cmd.burst_next = stat.out_free && !stat.cnt_last;
			end
			default: begin
				cmd.in_ready = rx_state && stat.out_free;
			end
		endcase
	end

endmodule

/* rtl/core/ufcd_dp.sv */
module ufcd_dp #(
	parameter int PAYLOAD_BYTES = ufcd_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [ufcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ufcd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [7:0]                      rx_byte,
	input  logic                            out_ready,
	input  ufcd_pkg::ufcd_cmd_t              cmd,
	output ufcd_pkg::ufcd_stat_t             stat,
	output logic                            out_valid,
	output logic [1:0]                      out_status,
	output logic [7:0]                      out_data,
	output logic                            out_last
);

	import ufcd_pkg::*;

	localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(PAYLOAD_BYTES - 1);
	localparam logic [7:0]    LEN_VAL  = 8'(PAYLOAD_BYTES);

	logic [7:0]    start_first_q;
	logic [7:0]    start_second_q;
	logic [15:0]   crc_seed_q;
	logic [15:0]   crc_q;
	logic [15:0]   crc_in;
	logic [15:0]   crc_next;
	logic [7:0]    hi_q;
	logic [AW-1:0] cnt_q;
	logic          ov_q;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_first_q  <= START_FIRST_RST;
			start_second_q <= START_SECOND_RST;
			crc_seed_q     <= CRC_SEED_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_START_FIRST:  start_first_q  <= cfg_data[7:0];
				CFG_START_SECOND: start_second_q <= cfg_data[7:0];
				CFG_CRC_SEED:     crc_seed_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign crc_in   = cmd.crc_seed_load ? crc_seed_q : crc_q;
	assign crc_next = crc_feed(crc_in, rx_byte);

	always_ff @(posedge clk) begin
		if (cmd.crc_seed_load || cmd.crc_update) begin
			crc_q <= crc_next;
		end
		if (cmd.hi_load) begin
			hi_q <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clear || cmd.rd_start) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc || cmd.burst_next) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	assign ram_re    = cmd.rd_start || cmd.burst_next;
	assign ram_raddr = cmd.rd_start ? '0 : cnt_q + AW'(1);

	ufcd_ram #(
		.WIDTH(8),
		.DEPTH(PAYLOAD_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (cmd.ram_we),
		.waddr(cnt_q),
		.wdata(rx_byte),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.drop_len || cmd.drop_crc || cmd.burst_load) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drop_len) begin
			out_status <= STATUS_BAD_LEN;
			out_data   <= 8'h00;
			out_last   <= 1'b1;
		end else if (cmd.drop_crc) begin
			out_status <= STATUS_BAD_CRC;
			out_data   <= 8'h00;
			out_last   <= 1'b1;
		end else if (cmd.burst_load) begin
			out_status <= STATUS_PAYLOAD;
			out_data   <= ram_rdata;
			out_last   <= (cnt_q == LAST_IDX);
		end
	end

	assign out_valid      = ov_q;
	assign stat.is_first  = (rx_byte == start_first_q);
	assign stat.is_second = (rx_byte == start_second_q);
	assign stat.len_ok    = (rx_byte == LEN_VAL);
	assign stat.crc_ok    = ({hi_q, rx_byte} == crc_q);
	assign stat.cnt_last  = (cnt_q == LAST_IDX);
	assign stat.out_free  = !ov_q || out_ready;

endmodule

/* rtl/core/uart_frame_crc_deframer.sv */
// Frame deframer for a received serial byte stream.
// s_axis carries one received byte per request. The block hunts the two
// start bytes, checks the length byte against PAYLOAD_BYTES, stores the
// payload, then checks a big-endian CRC-16 (poly 0x1021, seed from crc_seed)
// over length and payload.
// m_axis carries results: tuser is the status (payload, bad length, bad CRC),
// tdata the payload byte, tlast marks the final result caused by one byte.
// cfg writes the start bytes and CRC seed; index 0, 1, 2, others ignored.
// Throughput: one input byte per cycle while hunting and reading a frame, as long as the output register is free.
// A drop status is shown the cycle after the byte that causes it. A good
// frame starts a read of the payload RAM with its low CRC byte; each payload byte passes
// the RAM read register and then the output register, one byte per cycle while the
// receiver takes them. No input is taken during that burst.
// Reset returns the hunt to the first start byte and the registers to their
// defaults. When the receiver stalls, the output register holds its result
// and s_axis_tready is low until that result is taken.
module uart_frame_crc_deframer #(
	parameter int PAYLOAD_BYTES = ufcd_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ufcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ufcd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [7:0] rx_byte
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [7:0]                      m_axis_tdata,  // [7:0] data_byte
	output logic [1:0]                      m_axis_tuser,  // [1:0] status
	output logic                            m_axis_tlast
);

	import ufcd_pkg::*;

	ufcd_cmd_t  cmd;
	ufcd_stat_t stat;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = cmd.in_ready;

	ufcd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.stat    (stat),
		.cmd     (cmd)
	);

	ufcd_dp #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_byte   (s_axis_tdata),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_status(m_axis_tuser),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import ufcd_pkg::*;

	localparam int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF;
	localparam logic [7:0] LEN_BYTE = 8'(PAYLOAD_BYTES);
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
	localparam int LONG_STALL = 300;
	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = PAYLOAD_BYTES + 4;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] data;
		logic       last;
	} deframed_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [7:0]            m_axis_tdata;
	logic [1:0]            m_axis_tuser;
	logic                  m_axis_tlast;

	// frame tracker, mirrors the block
	logic [7:0]  sof_first = START_FIRST_RST;
	logic [7:0]  sof_second = START_SECOND_RST;
	logic [15:0] seed_reg = CRC_SEED_RST;
	ufcd_state_t frame_state = ST_SOF1;
	logic [7:0]  held_payload [PAYLOAD_BYTES];
	int          held_count = 0;
	logic [15:0] crc_acc = CRC_SEED_RST;
	logic [7:0]  crc_hi = 8'h00;
	deframed_t   awaited_results [$];

	logic [7:0]  frame_data [PAYLOAD_BYTES];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_order = 0;
	int stall_seen = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	bit offering = 1'b0;
	bit cfg_open = 1'b0;

	int fail_count = 0;
	int bytes_sent = 0;
	int reg_writes = 0;
	int payload_seen = 0;
	int len_drops = 0;
	int crc_drops = 0;

	uart_frame_crc_deframer #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		int k;
		c = crc ^ {b, 8'h00};
		for (k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	function automatic logic [15:0] frame_crc(input logic [15:0] seed);
		logic [15:0] c;
		int i;
		c = crc16_step(seed, LEN_BYTE);
		for (i = 0; i < PAYLOAD_BYTES; i++) begin
			c = crc16_step(c, frame_data[i]);
		end
		return c;
	endfunction

	function automatic deframed_t make_result(input logic [1:0] st, input logic [7:0] d,
			input logic l);
		deframed_t r;
		r.status = st;
		r.data = d;
		r.last = l;
		return r;
	endfunction

	task automatic deframe_byte(input logic [7:0] b);
		int i;
		case (frame_state)
			ST_SOF1: begin
				if (b == sof_first)
					frame_state = ST_SOF2;
			end
			ST_SOF2: begin
				if (b == sof_second)
					frame_state = ST_LEN;
				else if (b != sof_first)
					frame_state = ST_SOF1;
			end
			ST_LEN: begin
				if (b != LEN_BYTE) begin
					awaited_results.push_back(make_result(STATUS_BAD_LEN, 8'h00, 1'b1));
					frame_state = (b == sof_first) ? ST_SOF2 : ST_SOF1;
				end else begin
					crc_acc = crc16_step(seed_reg, b);
					held_count = 0;
					frame_state = ST_DATA;
				end
			end
			ST_DATA: begin
				held_payload[held_count] = b;
				crc_acc = crc16_step(crc_acc, b);
				held_count++;
				if (held_count >= PAYLOAD_BYTES)
					frame_state = ST_CRC_HI;
			end
			ST_CRC_HI: begin
				crc_hi = b;
				frame_state = ST_CRC_LO;
			end
			ST_CRC_LO: begin
				if ({crc_hi, b} == crc_acc) begin
					for (i = 0; i < PAYLOAD_BYTES; i++) begin
						awaited_results.push_back(make_result(STATUS_PAYLOAD, held_payload[i],
							i == PAYLOAD_BYTES - 1));
					end
				end else begin
					awaited_results.push_back(make_result(STATUS_BAD_CRC, 8'h00, 1'b1));
				end
				held_count = 0;
				frame_state = ST_SOF1;
			end
			default: begin
				frame_state = ST_SOF1;
			end
		endcase
	endtask

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("ERROR: %s", msg);
	endtask

	always @(posedge clk) begin
		deframed_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			case (m_axis_tuser)
				STATUS_PAYLOAD: payload_seen++;
				STATUS_BAD_LEN: len_drops++;
				STATUS_BAD_CRC: crc_drops++;
				default: ;
			endcase
			if (awaited_results.size() == 0) begin
				note_failure($sformatf("unexpected result status %0d data %02h last %0d",
					m_axis_tuser, m_axis_tdata, m_axis_tlast));
			end else begin
				want = awaited_results.pop_front();
				if (m_axis_tuser !== want.status || m_axis_tdata !== want.data ||
						m_axis_tlast !== want.last)
					note_failure($sformatf(
						"expected status %0d data %02h last %0d, got status %0d data %02h last %0d",
						want.status, want.data, want.last,
						m_axis_tuser, m_axis_tdata, m_axis_tlast));
			end
		end
	end

	// receiver: random back-pressure plus long hold-offs on request
	always @(posedge clk) begin
		if (stall_seen != stall_order) begin
			stall_seen <= stall_order;
			stall_left <= LONG_STALL;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: no request accepted for %0d cycles", QUIET_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic cfg_close;
		if (cfg_open) begin
			cfg_valid <= 1'b0;
			cfg_open = 1'b0;
		end
	endtask

	task automatic sender_halt;
		if (offering) begin
			s_axis_tvalid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		cfg_close();
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			if (offering)
				s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		offering = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		deframe_byte(b);
		bytes_sent++;
	endtask

	// block must have nothing in flight before a register write
	task automatic settle;
		cfg_close();
		sender_halt();
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		cfg_open = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_START_FIRST:  sof_first = val[7:0];
			CFG_START_SECOND: sof_second = val[7:0];
			CFG_CRC_SEED:     seed_reg = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic randomise_payload;
		int i;
		for (i = 0; i < PAYLOAD_BYTES; i++)
			frame_data[i] = 8'($urandom_range(0, 255));
	endtask

	task automatic send_frame(input bit spoil);
		logic [15:0] c;
		int i;
		c = frame_crc(seed_reg);
		if (spoil)
			c = c ^ (16'h0001 << $urandom_range(0, 15));
		send_byte(sof_first);
		send_byte(sof_second);
		send_byte(LEN_BYTE);
		for (i = 0; i < PAYLOAD_BYTES; i++)
			send_byte(frame_data[i]);
		send_byte(c[15:8]);
		send_byte(c[7:0]);
	endtask

	task automatic test_default_frames;
		int i;
		for (i = 0; i < PAYLOAD_BYTES; i++)
			frame_data[i] = i[0] ? 8'hFF : 8'h00;
		send_frame(1'b0);
		for (i = 0; i < PAYLOAD_BYTES; i++)
			frame_data[i] = 8'(i * 8'h11);
		send_frame(1'b0);
	endtask

	task automatic test_length_drops;
		send_byte(sof_first);
		send_byte(sof_second);
		send_byte(8'h00);
		// length equal to the first start byte resumes the hunt at the second
		send_byte(sof_first);
		send_byte(sof_second);
		send_byte(sof_first);
		send_byte(sof_second);
		send_byte(8'hFF);
		send_byte(sof_first);
		send_byte(sof_second);
		send_byte(LEN_BYTE + 8'd1);
	endtask

	task automatic test_repeated_start;
		send_byte(sof_first);
		send_byte(sof_first);
		randomise_payload();
		send_frame(1'b0);
	endtask

	task automatic test_crc_drop;
		randomise_payload();
		send_frame(1'b1);
	endtask

	task automatic test_registers;
		logic [15:0] c;
		int i;
		settle();
		write_reg(CFG_START_FIRST, 16'hFF00);
		write_reg(CFG_START_SECOND, 16'h00FF);
		write_reg(CFG_CRC_SEED, 16'h0000);
		randomise_payload();
		send_frame(1'b0);
		settle();
		write_reg(CFG_START_FIRST, 16'h00FF);
		write_reg(CFG_START_SECOND, 16'hFF00);
		write_reg(CFG_CRC_SEED, 16'hFFFF);
		randomise_payload();
		send_frame(1'b0);
		// both start bytes equal: the second-byte test wins
		settle();
		write_reg(CFG_START_FIRST, 16'h007E);
		write_reg(CFG_START_SECOND, 16'h007E);
		randomise_payload();
		send_frame(1'b0);
		settle();
		write_reg(CFG_UNUSED_IDX, 16'hA5C3);
		// seed written after the length byte applies to the next frame only
		send_byte(sof_first);
		send_byte(sof_second);
		send_byte(LEN_BYTE);
		randomise_payload();
		c = frame_crc(seed_reg);
		settle();
		write_reg(CFG_CRC_SEED, 16'h1D0F);
		for (i = 0; i < PAYLOAD_BYTES; i++)
			send_byte(frame_data[i]);
		send_byte(c[15:8]);
		send_byte(c[7:0]);
		randomise_payload();
		send_frame(1'b0);
		settle();
		write_reg(CFG_START_FIRST, {8'h5A, START_FIRST_RST});
		write_reg(CFG_START_SECOND, {8'hC3, START_SECOND_RST});
		write_reg(CFG_CRC_SEED, CRC_SEED_RST);
	endtask

	task automatic test_random(input int n_bytes);
		int target;
		int pick;
		int n;
		logic [7:0] len;
		settle();
		case ($urandom_range(0, 3))
			0: begin
				write_reg(CFG_START_FIRST, {8'h00, START_FIRST_RST});
				write_reg(CFG_START_SECOND, {8'h00, START_SECOND_RST});
				write_reg(CFG_CRC_SEED, CRC_SEED_RST);
			end
			1: begin
				write_reg(CFG_START_FIRST, 16'h0000);
				write_reg(CFG_START_SECOND, 16'hFFFF);
				write_reg(CFG_CRC_SEED, $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF);
			end
			default: begin
				write_reg(CFG_START_FIRST, 16'($urandom_range(0, 65535)));
				write_reg(CFG_START_SECOND, 16'($urandom_range(0, 65535)));
				write_reg(CFG_CRC_SEED, 16'($urandom_range(0, 65535)));
			end
		endcase
		target = bytes_sent + n_bytes;
		while (bytes_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				randomise_payload();
				send_frame(1'b0);
			end else if (pick < 72) begin
				randomise_payload();
				send_frame(1'b1);
			end else if (pick < 82) begin
				len = $urandom_range(0, 1) ? sof_first : 8'($urandom_range(0, 255));
				if (len == LEN_BYTE)
					len = len + 8'd1;
				send_byte(sof_first);
				send_byte(sof_second);
				send_byte(len);
			end else if (pick < 90) begin
				n = $urandom_range(1, 3);
				repeat (n) send_byte(sof_first);
				randomise_payload();
				send_frame(1'b0);
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic test_backpressure;
		stall_order++;
		randomise_payload();
		send_frame(1'b0);
		send_byte(sof_first);
		send_byte(sof_second);
		send_byte(8'h00);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 31;
		recv_idle_pct = 47;
		test_default_frames();
		test_length_drops();
		test_repeated_start();
		test_crc_drop();
		test_registers();
		test_random(5);

		send_idle_pct = 47;
		recv_idle_pct = 31;
		test_random(5);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(5);
		test_backpressure();

		settle();
		if (awaited_results.size() != 0)
			note_failure($sformatf("%0d results never arrived", awaited_results.size()));
		$display("Sent %0d bytes under three idling patterns with %0d register writes",
			bytes_sent, reg_writes);
		$display("Checked %0d payload bytes, %0d length drops and %0d CRC drops",
			payload_seen, len_drops, crc_drops);
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d failures", fail_count);
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/ufcd_pkg.sv
rtl/core/ufcd_ram.sv
rtl/core/ufcd_ctrl.sv
rtl/core/ufcd_dp.sv
rtl/core/uart_frame_crc_deframer.sv
sim/tb_top.sv
